[hdl/jse_pkg.sv]
// Package for the JSON string escaper: word types, descriptor format,
// escape tables. No dependencies.
`default_nettype none
package jse_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       starts_string;
    logic       ends_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_closed;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PLAIN = 2'd1,
    KIND_SHORT = 2'd2,
    KIND_UNI   = 2'd3
  } kind_t;

  // One classified item: which quotes, body kind, and the byte it needs
  // (raw byte, short escape letter, or the control code for \u00XX).
  typedef struct packed {
    logic       open_q;
    logic       close_q;
    kind_t      kind;
    logic [7:0] ch;
  } desc_t;

  function automatic logic [7:0] short_escape(input logic [7:0] ch);
    logic [7:0] r;
    case (ch)
      8'h5C:   r = 8'h5C;
      8'h22:   r = 8'h22;
      8'h08:   r = 8'h62;
      8'h0C:   r = 8'h66;
      8'h0A:   r = 8'h6E;
      8'h0D:   r = 8'h72;
      8'h09:   r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/jse_front.sv]
// Front stage: accepts input words, classifies them into descriptors.
// Depends on jse_pkg.
`default_nettype none
module jse_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire jse_pkg::in_item_t item,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output jse_pkg::desc_t        push_desc
);
  import jse_pkg::*;

  logic       valid;
  desc_t      desc;
  desc_t      desc_next;
  logic [7:0] esc;
  logic       has_res;

  always_comb begin
    esc = short_escape(item.data_byte);
    desc_next.open_q  = item.starts_string;
    desc_next.close_q = item.ends_string;
    desc_next.ch      = item.data_byte;
    if (!item.has_byte) begin
      desc_next.kind = KIND_NONE;
    end else if (esc != 8'h00) begin
      desc_next.kind = KIND_SHORT;
      desc_next.ch   = esc;
    end else if (item.data_byte < 8'h20 || item.data_byte == CH_DEL) begin
      desc_next.kind = KIND_UNI;
    end else begin
      desc_next.kind = KIND_PLAIN;
    end
    has_res = item.has_byte | item.starts_string | item.ends_string;
  end

  assign item_ready = !valid || push_ready;
  assign push_valid = valid;
  assign push_desc  = desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item_ready) begin
      valid <= item_valid && has_res;
    end
    if (item_valid && item_ready) begin
      desc <= desc_next;
    end
  end

endmodule
`default_nettype wire

[hdl/jse_fifo.sv]
// Descriptor queue between front and back stages.
// Depends on jse_pkg.
`default_nettype none
module jse_fifo #(
  parameter int unsigned Depth = jse_pkg::FIFO_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire jse_pkg::desc_t push_desc,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output jse_pkg::desc_t      pop_desc
);
  import jse_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  desc_t         mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FullCnt);
  assign pop_valid  = (count != '0);
  assign pop_desc   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FullCnt) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FullCnt) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule
`default_nettype wire

[hdl/jse_back.sv]
// Back stage: expands one descriptor into escaped output words, one
// per cycle unless stalled, to a registered output. Uses jse_pkg.
`default_nettype none
module jse_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  output logic                 head_pop,
  input  wire jse_pkg::desc_t  head,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output jse_pkg::out_item_t   res
);
  import jse_pkg::*;

  logic [2:0] step;
  logic [3:0] body_len;
  logic [3:0] total;
  logic [2:0] pos;
  logic       is_last;
  logic       advance;
  out_item_t  word_next;

  always_comb begin
    case (head.kind)
      KIND_NONE:  body_len = 4'd0;
      KIND_PLAIN: body_len = 4'd1;
      KIND_SHORT: body_len = 4'd2;
      KIND_UNI:   body_len = 4'd6;
      default:    body_len = 4'd0;
    endcase
    total   = body_len + {3'd0, head.open_q} + {3'd0, head.close_q};
    is_last = ({1'b0, step} == total - 4'd1);
    pos     = step - {2'd0, head.open_q};

    word_next.run_last      = is_last;
    word_next.string_closed = 1'b0;
    if (head.open_q && step == 3'd0) begin
      word_next.out_byte = CH_QUOTE;
    end else if (head.close_q && is_last) begin
      word_next.out_byte      = CH_QUOTE;
      word_next.string_closed = 1'b1;
    end else begin
      case (head.kind)
        KIND_SHORT: word_next.out_byte = (pos == 3'd0) ? CH_BSLASH : head.ch;
        KIND_UNI: begin
          case (pos)
            3'd0:    word_next.out_byte = CH_BSLASH;
            3'd1:    word_next.out_byte = CH_U;
            3'd4:    word_next.out_byte = hex_char(head.ch[7:4]);
            3'd5:    word_next.out_byte = hex_char(head.ch[3:0]);
            default: word_next.out_byte = CH_ZERO;
          endcase
        end
        default:    word_next.out_byte = head.ch;
      endcase
    end
  end

  assign advance  = (!res_valid || res_ready) && head_valid;
  assign head_pop = advance && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (!res_valid || res_ready) begin
        res_valid <= head_valid;
      end
      if (advance) begin
        step <= is_last ? 3'd0 : step + 3'd1;
      end
    end
    if (advance) begin
      res <= word_next;
    end
  end

  a_step_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> $stable(step))
    else $error("sequencer moved while output stalled");
  a_closed_is_quote: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.string_closed) |-> (res.out_byte == CH_QUOTE && res.run_last))
    else $error("closing flag on a non-final or non-quote word");
  a_pop_resets_step: assert property (@(posedge clk) disable iff (rst)
    head_pop |=> (step == 3'd0))
    else $error("step not cleared after descriptor done");

endmodule
`default_nettype wire

[hdl/json_string_escaper_top.sv]
// JSON string escaper top level: front classifier, descriptor queue,
// back expander. Depends on jse_pkg, jse_front, jse_fifo, jse_back.
//
// Each input word carries an optional string byte plus open/close quote
// flags; the block emits the JSON-escaped text one byte per output word,
// with run_last on the final word of each input word and string_closed on
// a closing quote. The back sequencer produces one output word per cycle
// while res_ready allows, and an input word causes 1 output word for a
// plain byte, 2 for a short escape, 6 for a \u00XX escape, plus 1 per
// quote. Plain bytes stream at one per cycle when the output is not
// stalled. Words that cause no output are dropped in the front stage.
// The first output word passes the front register, the descriptor queue
// and the back output register; the queue lets input run ahead of an
// expanding escape by FifoDepth descriptors.
`default_nettype none
module json_string_escaper_top #(
  parameter int unsigned FifoDepth = jse_pkg::FIFO_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire jse_pkg::in_item_t  item,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output jse_pkg::out_item_t      res
);
  import jse_pkg::*;

  logic  push_valid;
  logic  push_ready;
  desc_t push_desc;
  logic  head_valid;
  logic  head_pop;
  desc_t head;

  jse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  jse_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_desc   (head)
  );

  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Testbench for json_string_escaper_top: escape predictor, result scoreboard,
// directed and random string stimulus with random idling on both sides.
// Depends on jse_pkg and the RTL under hdl/.
package jse_tb_pkg;
  import jse_pkg::*;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_HIGH_LO   = 8'h80;
  localparam logic [7:0] CH_HIGH_HI   = 8'hFF;
  localparam logic [7:0] LET_B        = 8'h62;
  localparam logic [7:0] LET_F        = 8'h66;
  localparam logic [7:0] LET_N        = 8'h6E;
  localparam logic [7:0] LET_R        = 8'h72;
  localparam logic [7:0] LET_T        = 8'h74;
  localparam logic [7:0] NO_LETTER    = 8'h00;

  function automatic logic [7:0] escape_letter(logic [7:0] c);
    case (c)
      CH_BSLASH:    return CH_BSLASH;
      CH_QUOTE:     return CH_QUOTE;
      CH_BACKSPACE: return LET_B;
      CH_FF:        return LET_F;
      CH_LF:        return LET_N;
      CH_CR:        return LET_R;
      CH_TAB:       return LET_T;
      default:      return NO_LETTER;
    endcase
  endfunction

  class escape_scoreboard;
    out_item_t   expected_q[$];
    int unsigned n_in, n_out, n_short, n_uni, n_closed, n_errors;

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      n_errors++;
    endtask

    function void push_byte(logic [7:0] b, logic closed);
      out_item_t r;
      r.out_byte      = b;
      r.run_last      = 1'b0;
      r.string_closed = closed;
      expected_q.push_back(r);
    endfunction

    // Expand one accepted input word into its escaped output words.
    function void note_input(in_item_t w);
      string       digits = "0123456789ABCDEF";
      logic [7:0]  letter;
      int unsigned first;
      out_item_t   tail;
      first = expected_q.size();
      n_in++;
      if (w.starts_string) push_byte(CH_QUOTE, 1'b0);
      if (w.has_byte) begin
        letter = escape_letter(w.data_byte);
        if (letter != NO_LETTER) begin
          push_byte(CH_BSLASH, 1'b0);
          push_byte(letter, 1'b0);
          n_short++;
        end else if (w.data_byte < CH_SPACE || w.data_byte == CH_DEL) begin
          push_byte(CH_BSLASH, 1'b0);
          push_byte(CH_U, 1'b0);
          push_byte(CH_ZERO, 1'b0);
          push_byte(CH_ZERO, 1'b0);
          push_byte(digits[w.data_byte[7:4]], 1'b0);
          push_byte(digits[w.data_byte[3:0]], 1'b0);
          n_uni++;
        end else begin
          push_byte(w.data_byte, 1'b0);
        end
      end
      if (w.ends_string) begin
        push_byte(CH_QUOTE, 1'b1);
        n_closed++;
      end
      if (expected_q.size() > first) begin
        tail = expected_q.pop_back();
        tail.run_last = 1'b1;
        expected_q.push_back(tail);
      end
    endfunction

    task check(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word out_byte=%02h", got.out_byte));
        return;
      end
      want = expected_q.pop_front();
      n_out++;
      if (got.out_byte !== want.out_byte)
        report($sformatf("word %0d out_byte %02h, want %02h", n_out, got.out_byte,
                         want.out_byte));
      if (got.run_last !== want.run_last)
        report($sformatf("word %0d run_last %b, want %b", n_out, got.run_last,
                         want.run_last));
      if (got.string_closed !== want.string_closed)
        report($sformatf("word %0d string_closed %b, want %b", n_out,
                         got.string_closed, want.string_closed));
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass
endpackage

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jse_pkg::*;
  import jse_tb_pkg::*;

  localparam int unsigned N_RANDOM    = 370;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN       = 16;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  escape_scoreboard sb = new();
  int unsigned      idle_pct = 27;
  int unsigned      n_sent;
  int unsigned      quiet;

  json_string_escaper_top u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check(res);
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (res_valid && res_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", quiet);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic drive_word(in_item_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
      item       <= in_item_t'(11'($urandom));
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (!item_ready);
    sb.note_input(w);
    n_sent++;
  endtask

  function automatic in_item_t make_word(logic [7:0] b, logic has, logic st, logic en);
    in_item_t w;
    w.data_byte     = b;
    w.has_byte      = has;
    w.starts_string = st;
    w.ends_string   = en;
    return w;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] shorts [7] = '{CH_BSLASH, CH_QUOTE, CH_BACKSPACE, CH_FF, CH_LF,
                               CH_CR, CH_TAB};
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(0, 31));
      2:       return shorts[$urandom_range(0, 6)];
      3:       return CH_DEL;
      4, 5:    return 8'($urandom_range(CH_HIGH_LO, CH_HIGH_HI));
      default: return 8'($urandom_range(CH_SPACE, CH_TILDE));
    endcase
  endfunction

  task automatic send_string(int unsigned len);
    logic has;
    if (len == 0) begin
      drive_word(make_word(8'($urandom), 1'b0, 1'b1, 1'b1));
    end else begin
      for (int unsigned i = 0; i < len; i++) begin
        has = ($urandom_range(0, 19) != 0);
        drive_word(make_word(pick_byte(), has, i == 0, i == len - 1));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    n_sent     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: framing corner cases and every escape class
    drive_word(make_word(CH_HIGH_HI, 1'b0, 1'b0, 1'b0));
    drive_word(make_word(CH_BSLASH, 1'b0, 1'b1, 1'b1));
    drive_word(make_word("A", 1'b1, 1'b1, 1'b0));
    drive_word(make_word(CH_BSLASH, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_QUOTE, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_BACKSPACE, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_FF, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_LF, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_CR, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_TAB, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(8'h00, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(8'h1F, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_DEL, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_SPACE, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_TILDE, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_HIGH_LO, 1'b1, 1'b0, 1'b0));
    drive_word(make_word(CH_HIGH_HI, 1'b1, 1'b0, 1'b1));
    drive_word(make_word(8'h01, 1'b1, 1'b1, 1'b1));
    drive_word(make_word(8'h00, 1'b0, 1'b0, 1'b1));
    drive_word(make_word(CH_HIGH_HI, 1'b0, 1'b1, 1'b0));
    drive_word(make_word(CH_BSLASH, 1'b0, 1'b0, 1'b1));
    drive_word(make_word(8'h5A, 1'b0, 1'b0, 1'b0));

    // random: mostly framed strings, some loose words
    while (n_sent < N_RANDOM) begin
      idle_pct = (n_sent >= 140 && n_sent < 230) ? 0 : 27;
      if ($urandom_range(0, 99) < 15) begin
        drive_word(in_item_t'(11'($urandom)));
      end else if ($urandom_range(0, 9) == 0) begin
        send_string($urandom_range(11, 30));
      end else begin
        send_string($urandom_range(0, 10));
      end
    end
    idle_pct = 27;
    @(negedge clk);
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d words never arrived", sb.pending()));

    $display("Run: %0d input words, %0d output words checked, %0d closing quotes,",
             sb.n_in, sb.n_out, sb.n_closed);
    $display("     %0d short escapes, %0d \\u00XX escapes, %0d mismatches",
             sb.n_short, sb.n_uni, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
